/* rtl/broadcast_ring_admission_macros.svh */
// Assertion macros for the broadcast ring admission block.
// Used by the sequencer; needs a clock and an active-low reset name.
`ifndef BROADCAST_RING_ADMISSION_MACROS_SVH
`define BROADCAST_RING_ADMISSION_MACROS_SVH

// Same-cycle implication, off during reset.
`define BRA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bra assertion failed");

// Next-cycle implication, off during reset.
`define BRA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bra assertion failed");

`endif

/* rtl/bra_pkg.sv */
// Shared types, constants and helpers of the broadcast ring admission block.
// No dependencies.
package bra_pkg;

    localparam int SLOTS   = 64;
    localparam int READERS = 8;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int RDR_W   = $clog2(READERS);

    localparam int WORD_W   = 64;
    localparam int BYTES_W  = 16;
    localparam int RSLOT_W  = 3;
    localparam int STATUS_W = 2;
    localparam int CFG_SLOTS_W   = 7;
    localparam int CFG_READERS_W = 4;
    localparam int PADDR_W  = 6;

    localparam logic [BYTES_W-1:0] MIN_PAYLOAD_LIMIT = 16'd256;
    localparam logic [19:0]        MS_TO_TICKS       = 20'(1000 * 1000);
    localparam logic [63:0]        TMO_SAT_LIMIT     =
        64'hFFFF_FFFF_FFFF_FFFF / 64'(MS_TO_TICKS);
    localparam logic [63:0]        SEQ_ODD_STEP      = 64'd2;

    typedef enum logic [0:0] {
        FUNC_PUBLISH = 1'b0,
        FUNC_ENTRY   = 1'b1
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_PUBLISHED = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_DROPPED   = 2'd2,
        ST_ENTRY     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        REG_SLOTS       = 3'd0,
        REG_PAYLOAD_LIM = 3'd1,
        REG_READERS     = 3'd2,
        REG_DROP_OLDEST = 3'd3,
        REG_TIMEOUT     = 3'd4
    } t_reg_idx;

    typedef enum logic [0:0] {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef enum logic [4:0] {
        S_IDLE, S_ENTRY, S_SIZE, S_TMO_LO, S_TMO_HI, S_TMO_ADD, S_NEXT,
        S_SC_A, S_SC_B, S_SC_C, S_OVF, S_OVF_CMP, S_DROP_NEW, S_NEWMIN,
        S_DO_A, S_DO_B, S_DO_C, S_DO_SUM, S_SEQ_RD, S_SEQ_A, S_SEQ_B, S_RESULT
    } t_state;

    typedef struct packed {
        logic [CFG_SLOTS_W-1:0]   slots;
        logic [BYTES_W-1:0]       payload_limit;
        logic [CFG_READERS_W-1:0] readers;
        logic                     drop_oldest;
        logic [WORD_W-1:0]        stale_timeout;
    } t_cfg;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WORD_W-1:0]   message_index;
        logic [SLOT_W-1:0]   slot_number;
        logic [WORD_W-1:0]   slot_sequence;
        logic [WORD_W-1:0]   lost_now;
        logic [WORD_W-1:0]   newest_drops_total;
        logic [WORD_W-1:0]   oldest_drops_total;
        logic [WORD_W-1:0]   entry_lost_total;
    } t_result;

    function automatic logic [CFG_SLOTS_W-1:0] eff_slots(input logic [CFG_SLOTS_W-1:0] v);
        logic [CFG_SLOTS_W-1:0] r;
        r = v;
        if (v == '0) r = CFG_SLOTS_W'(1);
        else if (v > CFG_SLOTS_W'(SLOTS)) r = CFG_SLOTS_W'(SLOTS);
        return r;
    endfunction

    function automatic logic [CFG_READERS_W-1:0] eff_readers(
        input logic [CFG_READERS_W-1:0] v);
        logic [CFG_READERS_W-1:0] r;
        r = v;
        if (v == '0) r = CFG_READERS_W'(1);
        else if (v > CFG_READERS_W'(READERS)) r = CFG_READERS_W'(READERS);
        return r;
    endfunction

endpackage

/* rtl/bra_ifs.sv */
// Valid/ready channel interfaces for publish/entry words and result words.
// Depends on bra_pkg.
interface bra_in_if import bra_pkg::*;;
    logic                valid;
    logic                ready;
    logic                func;
    logic [WORD_W-1:0]   now_time;
    logic [BYTES_W-1:0]  message_bytes;
    logic [RSLOT_W-1:0]  reader_slot;
    logic                reader_active;
    logic [WORD_W-1:0]   reader_position;
    logic [WORD_W-1:0]   reader_seen_time;

    modport source(output valid, func, now_time, message_bytes, reader_slot,
                   reader_active, reader_position, reader_seen_time, input ready);
    modport sink(input valid, func, now_time, message_bytes, reader_slot,
                 reader_active, reader_position, reader_seen_time, output ready);
endinterface

interface bra_out_if import bra_pkg::*;;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   message_index;
    logic [SLOT_W-1:0]   slot_number;
    logic [WORD_W-1:0]   slot_sequence;
    logic [WORD_W-1:0]   lost_now;
    logic [WORD_W-1:0]   newest_drops_total;
    logic [WORD_W-1:0]   oldest_drops_total;
    logic [WORD_W-1:0]   entry_lost_total;

    modport source(output valid, status, message_index, slot_number, slot_sequence,
                   lost_now, newest_drops_total, oldest_drops_total,
                   entry_lost_total, input ready);
    modport sink(input valid, status, message_index, slot_number, slot_sequence,
                 lost_now, newest_drops_total, oldest_drops_total,
                 entry_lost_total, output ready);
endinterface

/* rtl/bra_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bra_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* rtl/bra_alu.sv */
// Shared 64-bit add/subtract unit with borrow out.
// Depends on bra_pkg.
module bra_alu import bra_pkg::*; (
    input  t_alu_op           i_op,
    input  logic [WORD_W-1:0] i_a,
    input  logic [WORD_W-1:0] i_b,
    output logic [WORD_W-1:0] o_res,
    output logic              o_borrow
);
    logic [WORD_W:0] sum;

    always_comb begin
        case (i_op)
            ALU_SUB: sum = {1'b0, i_a} + {1'b0, ~i_b} + (WORD_W+1)'(1);
            default: sum = {1'b0, i_a} + {1'b0, i_b};
        endcase
    end

    assign o_res    = sum[WORD_W-1:0];
    // borrow means a < b on subtract
    assign o_borrow = (i_op == ALU_SUB) && !sum[WORD_W];
endmodule

/* rtl/bra_regs.sv */
// APB-style configuration registers of the broadcast ring admission block.
// Depends on bra_pkg.
module bra_regs import bra_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    output t_cfg               o_cfg
);
    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr;

    assign idx    = t_reg_idx'(paddr[PADDR_W-1:3]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slots         <= CFG_SLOTS_W'(64);
            r_cfg.payload_limit <= MIN_PAYLOAD_LIMIT;
            r_cfg.readers       <= CFG_READERS_W'(8);
            r_cfg.drop_oldest   <= 1'b0;
            r_cfg.stale_timeout <= '0;
        end else if (wr) begin
            case (idx)
                REG_SLOTS:       r_cfg.slots         <= pwdata[CFG_SLOTS_W-1:0];
                REG_PAYLOAD_LIM: r_cfg.payload_limit <= pwdata[BYTES_W-1:0];
                REG_READERS:     r_cfg.readers       <= pwdata[CFG_READERS_W-1:0];
                REG_DROP_OLDEST: r_cfg.drop_oldest   <= pwdata[0];
                REG_TIMEOUT:     r_cfg.stale_timeout <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_SLOTS:       prdata = 64'(r_cfg.slots);
            REG_PAYLOAD_LIM: prdata = 64'(r_cfg.payload_limit);
            REG_READERS:     prdata = 64'(r_cfg.readers);
            REG_DROP_OLDEST: prdata = 64'(r_cfg.drop_oldest);
            REG_TIMEOUT:     prdata = r_cfg.stale_timeout;
            default:         prdata = '0;
        endcase
    end
endmodule

/* rtl/bra_seq.sv */
// Sequencer, reader table and seqlock store of the broadcast ring admission block.
// Depends on bra_pkg, bra_ifs, bra_alu, bra_ram and the assertion macros.
`include "broadcast_ring_admission_macros.svh"
module bra_seq import bra_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    bra_in_if.sink    i_in,
    input  logic      i_res_ready,
    output logic      o_res_valid,
    output t_result   o_res
);
    t_state r_state, n_state;

    // latched input word
    logic [WORD_W-1:0]   r_now;
    logic [BYTES_W-1:0]  r_bytes;
    logic [RSLOT_W-1:0]  r_rslot;
    logic                r_ract;
    logic [WORD_W-1:0]   r_rpos;
    logic [WORD_W-1:0]   r_rseen;

    // persistent state
    logic [WORD_W-1:0]   r_wp, r_newest, r_oldest;
    logic [READERS-1:0]  r_act;
    logic [WORD_W-1:0]   r_pos  [READERS];
    logic [WORD_W-1:0]   r_seen [READERS];
    logic [WORD_W-1:0]   r_lost [READERS];
    logic [SLOTS-1:0]    r_seq_vld;

    // working registers
    logic [WORD_W-1:0]   r_tmo, r_prod, r_next, r_min, r_diff, r_newmin;
    logic [WORD_W-1:0]   r_lost_now, r_seq, r_entry_lost;
    logic [RDR_W-1:0]    r_idx;
    t_status             r_status;

    // bit-serial remainder of next index by slot count
    logic [WORD_W-1:0]   r_mod_q;
    logic [SLOT_W-1:0]   r_rem;
    logic [5:0]          r_mod_cnt;
    logic                r_mod_busy, r_mod_done;
    logic [SLOT_W:0]     mod_t;
    logic [SLOT_W-1:0]   mod_rem_nxt;

    logic [CFG_SLOTS_W-1:0]   slots_e;
    logic [CFG_READERS_W-1:0] nr_e;
    logic [BYTES_W-1:0]       limit_e;
    logic [WORD_W-1:0]        slots_w;
    logic                     in_fire, scan_last, entry_ok;
    logic                     cur_act;
    logic [WORD_W-1:0]        cur_pos, cur_seen, cur_lost, s0;

    logic [31:0]              mul_a;
    logic [51:0]              mul_res;

    t_alu_op                  alu_op;
    logic [WORD_W-1:0]        alu_a, alu_b, alu_res;
    logic                     alu_borrow;

    logic                     ram_we;
    logic [WORD_W-1:0]        ram_rdata;

    assign slots_e   = eff_slots(i_cfg.slots);
    assign nr_e      = eff_readers(i_cfg.readers);
    assign limit_e   = (i_cfg.payload_limit < MIN_PAYLOAD_LIMIT) ? MIN_PAYLOAD_LIMIT
                                                                  : i_cfg.payload_limit;
    assign slots_w   = WORD_W'(slots_e);
    assign in_fire   = i_in.valid && i_in.ready;
    assign scan_last = ({1'b0, r_idx} == (nr_e - CFG_READERS_W'(1)));
    assign entry_ok  = (32'(r_rslot) < 32'(READERS));

    assign cur_act   = r_act[r_idx];
    assign cur_pos   = r_pos[r_idx];
    assign cur_seen  = r_seen[r_idx];
    assign cur_lost  = r_lost[r_idx];
    assign s0        = r_seq_vld[r_rem] ? ram_rdata : '0;

    assign mod_t       = {r_rem, r_mod_q[WORD_W-1]};
    assign mod_rem_nxt = (mod_t >= (SLOT_W+1)'(slots_e)) ?
                         SLOT_W'(mod_t - (SLOT_W+1)'(slots_e)) : SLOT_W'(mod_t);

    assign mul_a   = (r_state == S_TMO_LO) ? i_cfg.stale_timeout[31:0]
                                           : i_cfg.stale_timeout[63:32];
    assign mul_res = 52'(mul_a) * 52'(MS_TO_TICKS);

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_RESULT);
    assign ram_we      = (r_state == S_SEQ_B);

    bra_alu u_alu (
        .i_op     (alu_op),
        .i_a      (alu_a),
        .i_b      (alu_b),
        .o_res    (alu_res),
        .o_borrow (alu_borrow)
    );

    bra_ram #(.WIDTH(WORD_W), .DEPTH(SLOTS)) u_seq_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_rem),
        .i_wdata (alu_res),
        .i_raddr (r_rem),
        .o_rdata (ram_rdata)
    );

    // ALU operand selection
    always_comb begin
        alu_op = ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;
        case (r_state)
            S_TMO_ADD:  begin alu_a = r_tmo; alu_b = {r_prod[31:0], 32'h0}; end
            S_NEXT:     begin alu_a = r_wp; alu_b = WORD_W'(1); end
            S_SC_A:     begin alu_op = ALU_SUB; alu_a = r_now; alu_b = cur_seen; end
            S_SC_B:     begin alu_op = ALU_SUB; alu_a = r_tmo; alu_b = r_diff; end
            S_SC_C:     begin alu_op = ALU_SUB; alu_a = cur_pos; alu_b = r_min; end
            S_OVF:      begin alu_op = ALU_SUB; alu_a = r_next; alu_b = r_min; end
            S_OVF_CMP:  begin alu_op = ALU_SUB; alu_a = slots_w; alu_b = r_diff; end
            S_DROP_NEW: begin alu_a = r_newest; alu_b = WORD_W'(1); end
            S_NEWMIN:   begin alu_op = ALU_SUB; alu_a = r_next; alu_b = slots_w; end
            S_DO_A:     begin alu_op = ALU_SUB; alu_a = r_newmin; alu_b = cur_pos; end
            S_DO_B:     begin alu_a = cur_lost; alu_b = r_diff; end
            S_DO_C:     begin alu_a = r_lost_now; alu_b = r_diff; end
            S_DO_SUM:   begin alu_a = r_oldest; alu_b = r_lost_now; end
            S_SEQ_A:    begin alu_a = s0; alu_b = s0[0] ? SEQ_ODD_STEP : WORD_W'(1); end
            S_SEQ_B:    begin alu_a = r_seq; alu_b = WORD_W'(1); end
            default: ;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (in_fire) begin
                n_state = (i_in.func == FUNC_ENTRY) ? S_ENTRY : S_SIZE;
            end
            S_ENTRY:   n_state = S_RESULT;
            S_SIZE:    n_state = (r_bytes > limit_e) ? S_RESULT : S_TMO_LO;
            S_TMO_LO:  n_state = S_TMO_HI;
            S_TMO_HI:  n_state = S_TMO_ADD;
            S_TMO_ADD: n_state = S_NEXT;
            S_NEXT:    n_state = S_SC_A;
            S_SC_A: begin
                if (!cur_act) begin
                    n_state = scan_last ? S_OVF : S_SC_A;
                end else if (r_tmo == '0 || cur_seen == '0 || alu_borrow ||
                             alu_res == '0) begin
                    n_state = S_SC_C;
                end else begin
                    n_state = S_SC_B;
                end
            end
            S_SC_B: begin
                if (alu_borrow) n_state = scan_last ? S_OVF : S_SC_A;
                else            n_state = S_SC_C;
            end
            S_SC_C:    n_state = scan_last ? S_OVF : S_SC_A;
            S_OVF:     n_state = S_OVF_CMP;
            S_OVF_CMP: begin
                // hold a dropped word until the remainder unit is idle
                if (!alu_borrow)            n_state = S_SEQ_RD;
                else if (i_cfg.drop_oldest) n_state = S_NEWMIN;
                else if (r_mod_done)        n_state = S_DROP_NEW;
            end
            S_DROP_NEW: n_state = S_RESULT;
            S_NEWMIN:   n_state = S_DO_A;
            S_DO_A: begin
                if (cur_act && !alu_borrow && alu_res != '0) n_state = S_DO_B;
                else n_state = scan_last ? S_DO_SUM : S_DO_A;
            end
            S_DO_B:    n_state = S_DO_C;
            S_DO_C:    n_state = scan_last ? S_DO_SUM : S_DO_A;
            S_DO_SUM:  n_state = S_SEQ_RD;
            S_SEQ_RD:  if (r_mod_done) begin
                n_state = S_SEQ_A;
            end
            S_SEQ_A:   n_state = S_SEQ_B;
            S_SEQ_B:   n_state = S_RESULT;
            S_RESULT:  if (i_res_ready) begin
                n_state = S_IDLE;
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // result word
    always_comb begin
        o_res.status             = r_status;
        o_res.message_index      = r_wp;
        o_res.slot_number        = (r_status == ST_PUBLISHED) ? r_rem : '0;
        o_res.slot_sequence      = (r_status == ST_PUBLISHED) ? r_seq : '0;
        o_res.lost_now           = (r_status == ST_PUBLISHED) ? r_lost_now : '0;
        o_res.newest_drops_total = r_newest;
        o_res.oldest_drops_total = r_oldest;
        o_res.entry_lost_total   = (r_status == ST_ENTRY) ? r_entry_lost : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_wp       <= '0;
            r_newest   <= '0;
            r_oldest   <= '0;
            r_act      <= '0;
            r_pos      <= '{default: '0};
            r_seen     <= '{default: '0};
            r_lost     <= '{default: '0};
            r_seq_vld  <= '0;
            r_mod_busy <= 1'b0;
            r_mod_done <= 1'b0;
        end else begin
            r_state <= n_state;

            if (r_mod_busy) begin
                r_rem     <= mod_rem_nxt;
                r_mod_q   <= {r_mod_q[WORD_W-2:0], 1'b0};
                r_mod_cnt <= r_mod_cnt + 6'd1;
                if (&r_mod_cnt) begin
                    r_mod_busy <= 1'b0;
                    r_mod_done <= 1'b1;
                end
            end

            case (r_state)
                S_IDLE: if (in_fire) begin
                    r_now        <= i_in.now_time;
                    r_bytes      <= i_in.message_bytes;
                    r_rslot      <= i_in.reader_slot;
                    r_ract       <= i_in.reader_active;
                    r_rpos       <= i_in.reader_position;
                    r_rseen      <= i_in.reader_seen_time;
                    r_lost_now   <= '0;
                    r_entry_lost <= '0;
                end
                S_ENTRY: begin
                    r_status <= ST_ENTRY;
                    if (entry_ok) begin
                        r_act[r_rslot[RDR_W-1:0]]  <= r_ract;
                        r_pos[r_rslot[RDR_W-1:0]]  <= r_rpos;
                        r_seen[r_rslot[RDR_W-1:0]] <= r_rseen;
                        r_entry_lost               <= r_lost[r_rslot[RDR_W-1:0]];
                    end
                end
                S_SIZE:    r_status <= ST_TOO_LARGE;
                S_TMO_LO:  r_tmo  <= WORD_W'(mul_res);
                S_TMO_HI:  r_prod <= WORD_W'(mul_res);
                S_TMO_ADD: r_tmo  <= (i_cfg.stale_timeout > TMO_SAT_LIMIT) ? '1 : alu_res;
                S_NEXT: begin
                    r_next     <= alu_res;
                    r_min      <= r_wp;
                    r_idx      <= '0;
                    r_mod_q    <= alu_res;
                    r_rem      <= '0;
                    r_mod_cnt  <= '0;
                    r_mod_busy <= 1'b1;
                end
                S_SC_A: begin
                    r_diff <= alu_res;
                    if (!cur_act && !scan_last) r_idx <= r_idx + RDR_W'(1);
                end
                S_SC_B: if (alu_borrow) begin
                    // retire stale reader
                    r_act[r_idx] <= 1'b0;
                    if (!scan_last) r_idx <= r_idx + RDR_W'(1);
                end
                S_SC_C: begin
                    if (alu_borrow) r_min <= cur_pos;
                    if (!scan_last) r_idx <= r_idx + RDR_W'(1);
                end
                S_OVF:      r_diff <= alu_res;
                S_DROP_NEW: begin
                    r_newest <= alu_res;
                    r_status <= ST_DROPPED;
                end
                S_NEWMIN: begin
                    r_newmin <= alu_res;
                    r_idx    <= '0;
                end
                S_DO_A: begin
                    r_diff <= alu_res;
                    if (!(cur_act && !alu_borrow && alu_res != '0) && !scan_last) begin
                        r_idx <= r_idx + RDR_W'(1);
                    end
                end
                S_DO_B: begin
                    // advance lagging reader, charge its loss
                    r_pos[r_idx]  <= r_newmin;
                    r_lost[r_idx] <= alu_res;
                end
                S_DO_C: begin
                    r_lost_now <= alu_res;
                    if (!scan_last) r_idx <= r_idx + RDR_W'(1);
                end
                S_DO_SUM: r_oldest <= alu_res;
                S_SEQ_A:  r_seq    <= alu_res;
                S_SEQ_B: begin
                    r_seq            <= alu_res;
                    r_seq_vld[r_rem] <= 1'b1;
                    r_wp             <= r_next;
                    r_status         <= ST_PUBLISHED;
                end
                S_RESULT: if (i_res_ready) begin
                    r_mod_done <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    `BRA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_fire, r_state != S_IDLE)
    `BRA_ASSERT_NOW(a_rem_in_ring, i_clk, i_rst_n, r_mod_done,
                    (CFG_SLOTS_W'(r_rem) < slots_e))
    `BRA_ASSERT_NOW(a_seq_even, i_clk, i_rst_n, r_state == S_SEQ_B, !alu_res[0])
    `BRA_ASSERT_NOW(a_scan_in_range, i_clk, i_rst_n,
                    (r_state == S_SC_A || r_state == S_DO_A),
                    (CFG_READERS_W'(r_idx) < nr_e))
endmodule

/* rtl/broadcast_ring_admission.sv */
// Broadcast ring admission controller, top level.
// Input channel takes publish or reader-entry words; output channel returns
// one result word per input word. Configuration through the APB-style port.
// Registers at byte address 8*i: slots, payload limit, readers, drop-oldest
// mode, stale timeout (64-bit data).
// One word is processed at a time; input ready is low while it is worked on.
// Entry writes and oversize publishes pass from acceptance through the entry or
// size check state straight to the result state. Other publishes run a 64-step
// bit-serial remainder (write index modulo slots) alongside the reader scans on
// the shared 64-bit adder; each scan pass ends before the remainder and waits for
// it, then a dropped publish goes through the drop state and a published one
// through the sequence read, update and write states before the result state.
// Result words sit in an output register; the next input word is accepted
// while a result waits, and the sequencer holds its next result until the
// register frees up, so a stalled receiver backs up to the input.
// Synchronous active-low reset clears counters, reader table and slot
// seqlock valid bits at once; no clearing pass is needed.
module broadcast_ring_admission import bra_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    bra_in_if.sink             i_in_ch,
    bra_out_if.source          o_out_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);
    t_cfg    cfg;
    t_result res, r_out;
    logic    res_valid, res_ready, r_ovalid;

    bra_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bra_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in        (i_in_ch),
        .i_res_ready (res_ready),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // output register: load when empty or being drained
    assign res_ready = !r_ovalid || o_out_ch.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_ready) begin
            r_ovalid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_ch.valid              = r_ovalid;
    assign o_out_ch.status             = r_out.status;
    assign o_out_ch.message_index      = r_out.message_index;
    assign o_out_ch.slot_number        = r_out.slot_number;
    assign o_out_ch.slot_sequence      = r_out.slot_sequence;
    assign o_out_ch.lost_now           = r_out.lost_now;
    assign o_out_ch.newest_drops_total = r_out.newest_drops_total;
    assign o_out_ch.oldest_drops_total = r_out.oldest_drops_total;
    assign o_out_ch.entry_lost_total   = r_out.entry_lost_total;
endmodule

/* dv/tb_broadcast_ring_admission.sv */
// Testbench for the broadcast ring admission controller: publish and reader-entry
// words are sent, results are checked against a cycle-free predictor of the block.
// Depends on bra_pkg, bra_ifs.sv and broadcast_ring_admission.sv.
module tb_broadcast_ring_admission;
    import bra_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    bra_in_if  in_ch();
    bra_out_if out_ch();

    broadcast_ring_admission u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch.sink),
        .o_out_ch (out_ch.source),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // predictor state
    logic [6:0]  cfg_slots;
    logic [15:0] cfg_limit;
    logic [3:0]  cfg_readers;
    logic        cfg_oldest;
    logic [63:0] cfg_timeout;
    logic [63:0] wr_pos;
    logic [63:0] seq_words [SLOTS];
    logic        rd_active [READERS];
    logic [63:0] rd_pos    [READERS];
    logic [63:0] rd_seen   [READERS];
    logic [63:0] rd_lost   [READERS];
    logic [63:0] newest_drops;
    logic [63:0] oldest_drops;

    t_result expected_results [$];
    int      mismatches;
    int      send_idle_pct;
    int      recv_idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #50000000;
        $display("** broadcast_ring_admission: FAILED **");
        $finish;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
        $display("mismatch %s: got %h expected %h", what, got, exp);
        mismatches++;
    endtask

    function automatic logic [63:0] timeout_ticks();
        logic [127:0] p;
        p = 128'(cfg_timeout) * 128'(64'd1000000);
        return (p[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : p[63:0];
    endfunction

    function automatic t_result predict_admission(
        input logic f, input logic [63:0] now, input logic [15:0] bytes,
        input logic [2:0] rs, input logic act, input logic [63:0] pos,
        input logic [63:0] seen);
        t_result r;
        logic [63:0] lim, slots, nr, tmo, min_rd, nxt, new_min, idx, s0;
        logic dropped;
        r = '0;
        dropped = 1'b0;
        if (f == FUNC_ENTRY) begin
            r.status = ST_ENTRY;
            if (rs < READERS) begin
                rd_active[rs] = act;
                rd_pos[rs] = pos;
                rd_seen[rs] = seen;
                r.entry_lost_total = rd_lost[rs];
            end
        end else begin
            lim = (cfg_limit < 16'd256) ? 64'd256 : 64'(cfg_limit);
            if (64'(bytes) > lim) begin
                r.status = ST_TOO_LARGE;
            end else begin
                slots = (cfg_slots == 0) ? 1 : (cfg_slots > SLOTS) ? SLOTS : 64'(cfg_slots);
                nr = (cfg_readers == 0) ? 1 : (cfg_readers > READERS) ? READERS
                     : 64'(cfg_readers);
                tmo = timeout_ticks();
                min_rd = wr_pos;
                nxt = wr_pos + 1;
                for (int i = 0; i < nr; i++) begin
                    if (!rd_active[i]) continue;
                    if (tmo != 0 && rd_seen[i] != 0 && now > rd_seen[i]
                        && (now - rd_seen[i]) > tmo) begin
                        rd_active[i] = 1'b0;
                        continue;
                    end
                    if (rd_pos[i] < min_rd) min_rd = rd_pos[i];
                end
                if ((nxt - min_rd) > slots) begin
                    if (!cfg_oldest) begin
                        newest_drops++;
                        dropped = 1'b1;
                    end else begin
                        new_min = nxt - slots;
                        for (int i = 0; i < nr; i++) begin
                            if (!rd_active[i] || rd_pos[i] >= new_min) continue;
                            rd_lost[i] += new_min - rd_pos[i];
                            r.lost_now += new_min - rd_pos[i];
                            rd_pos[i] = new_min;
                        end
                        oldest_drops += r.lost_now;
                    end
                end
                if (dropped) begin
                    r.status = ST_DROPPED;
                    r.lost_now = '0;
                end else begin
                    idx = nxt % slots;
                    s0 = seq_words[idx];
                    s0 += s0[0] ? SEQ_ODD_STEP : 64'd1;
                    s0 += 1;
                    seq_words[idx] = s0;
                    wr_pos = nxt;
                    r.status = ST_PUBLISHED;
                    r.slot_number = idx[SLOT_W-1:0];
                    r.slot_sequence = s0;
                end
            end
        end
        r.message_index = wr_pos;
        r.newest_drops_total = newest_drops;
        r.oldest_drops_total = oldest_drops;
        return r;
    endfunction

    // one word into the block; prediction is made at acceptance
    task automatic send_word(
        input logic f, input logic [63:0] now, input logic [15:0] bytes,
        input logic [2:0] rs, input logic act, input logic [63:0] pos,
        input logic [63:0] seen);
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.func <= f;
        in_ch.now_time <= now;
        in_ch.message_bytes <= bytes;
        in_ch.reader_slot <= rs;
        in_ch.reader_active <= act;
        in_ch.reader_position <= pos;
        in_ch.reader_seen_time <= seen;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        expected_results.push_back(predict_admission(f, now, bytes, rs, act, pos, seen));
        in_ch.valid <= 1'b0;
        // block stays busy past this edge; no accept is lost
        @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [63:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(8 * idx);
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_SLOTS:       cfg_slots = val[6:0];
            REG_PAYLOAD_LIM: cfg_limit = val[15:0];
            REG_READERS:     cfg_readers = val[3:0];
            REG_DROP_OLDEST: cfg_oldest = val[0];
            default:         cfg_timeout = val;
        endcase
        @(posedge i_clk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (expected_results.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (150) @(posedge i_clk);
    endtask

    task automatic configure(input logic [6:0] sl, input logic [15:0] lim,
                             input logic [3:0] nr, input logic old, input logic [63:0] tmo);
        drain();
        write_reg(REG_SLOTS, 64'(sl));
        write_reg(REG_PAYLOAD_LIM, 64'(lim));
        write_reg(REG_READERS, 64'(nr));
        write_reg(REG_DROP_OLDEST, 64'(old));
        write_reg(REG_TIMEOUT, tmo);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // receiver with random stall
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                report("unexpected result", 64'(out_ch.status), 64'd0);
            end else begin
                e = expected_results.pop_front();
                if (out_ch.status !== e.status)
                    report("status", 64'(out_ch.status), 64'(e.status));
                if (out_ch.message_index !== e.message_index)
                    report("message_index", out_ch.message_index, e.message_index);
                if (out_ch.slot_number !== e.slot_number)
                    report("slot_number", 64'(out_ch.slot_number), 64'(e.slot_number));
                if (out_ch.slot_sequence !== e.slot_sequence)
                    report("slot_sequence", out_ch.slot_sequence, e.slot_sequence);
                if (out_ch.lost_now !== e.lost_now)
                    report("lost_now", out_ch.lost_now, e.lost_now);
                if (out_ch.newest_drops_total !== e.newest_drops_total)
                    report("newest_drops", out_ch.newest_drops_total, e.newest_drops_total);
                if (out_ch.oldest_drops_total !== e.oldest_drops_total)
                    report("oldest_drops", out_ch.oldest_drops_total, e.oldest_drops_total);
                if (out_ch.entry_lost_total !== e.entry_lost_total)
                    report("entry_lost", out_ch.entry_lost_total, e.entry_lost_total);
            end
        end
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic test_directed();
        // entry writes, including a never-seen reader and the top reader slot
        send_word(FUNC_ENTRY, '0, '0, 3'd0, 1'b1, 64'd0, 64'd0);
        send_word(FUNC_ENTRY, '0, '0, 3'd7, 1'b1, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(FUNC_PUBLISH, 64'hFFFF_FFFF_FFFF_FFFF, 16'd256, '0, '0, '0, '0);
        send_word(FUNC_PUBLISH, '0, 16'd257, '0, '0, '0, '0);
        send_word(FUNC_PUBLISH, '0, 16'hFFFF, '0, '0, '0, '0);
        send_word(FUNC_PUBLISH, '0, 16'd0, '0, '0, '0, '0);
        // small ring, drop newest fills quickly
        configure(7'd2, 16'd0, 4'd0, 1'b0, 64'd0);
        repeat (4) send_word(FUNC_PUBLISH, 64'd5, 16'd10, '0, '0, '0, '0);
        // drop oldest: readers forced forward
        configure(7'd3, 16'hFFFF, 4'd15, 1'b1, 64'd0);
        send_word(FUNC_PUBLISH, 64'd5, 16'hFFFF, '0, '0, '0, '0);
        send_word(FUNC_ENTRY, '0, '0, 3'd7, 1'b1, 64'd0, 64'd0);
        repeat (3) send_word(FUNC_PUBLISH, 64'd5, 16'd1, '0, '0, '0, '0);
        // staleness with saturating timeout, then with a short one
        configure(7'd127, 16'd300, 4'd8, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(FUNC_PUBLISH, 64'hFFFF_FFFF_FFFF_FFFF, 16'd1, '0, '0, '0, '0);
        configure(7'd1, 16'd300, 4'd8, 1'b0, 64'd1);
        send_word(FUNC_ENTRY, '0, '0, 3'd1, 1'b1, 64'd0, 64'd10);
        send_word(FUNC_PUBLISH, 64'd1000011, 16'd1, '0, '0, '0, '0);
        send_word(FUNC_PUBLISH, 64'd2000000, 16'd1, '0, '0, '0, '0);
    endtask

    task automatic test_random(input int n);
        logic [63:0] base;
        for (int k = 0; k < n; k++) begin
            base = (wr_pos > 70) ? wr_pos - 64'($urandom_range(70)) : 64'(0);
            if ($urandom_range(99) < 30)
                send_word(FUNC_ENTRY, rand64(), 16'($urandom()), 3'($urandom()),
                          1'($urandom()),
                          ($urandom_range(9) == 0) ? rand64() : base,
                          ($urandom_range(3) == 0) ? rand64()
                          : 64'($urandom_range(5)) * 64'd1000000);
            else
                send_word(FUNC_PUBLISH,
                          ($urandom_range(7) == 0) ? rand64()
                          : 64'($urandom_range(20)) * 64'd1000000,
                          ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(300)),
                          3'($urandom()), 1'($urandom()), rand64(), rand64());
        end
    endtask

    task automatic test_phases();
        configure(7'd8, 16'd256, 4'd4, 1'b1, 64'd3);
        test_random(180);
        send_idle_pct = 76;
        recv_idle_pct = 35;
        configure(7'd64, 16'd1000, 4'd8, 1'b0, 64'd2);
        test_random(180);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        configure(7'(1 + $urandom_range(64)), 16'($urandom()), 4'($urandom()),
                  1'b1, 64'd5);
        test_random(170);
    endtask

    initial begin
        mismatches = 0;
        send_idle_pct = 35;
        recv_idle_pct = 76;
        cfg_slots = 7'd64;
        cfg_limit = 16'd256;
        cfg_readers = 4'd8;
        cfg_oldest = 1'b0;
        cfg_timeout = '0;
        wr_pos = '0;
        newest_drops = '0;
        oldest_drops = '0;
        for (int i = 0; i < SLOTS; i++) seq_words[i] = '0;
        for (int i = 0; i < READERS; i++) begin
            rd_active[i] = 1'b0;
            rd_pos[i] = '0;
            rd_seen[i] = '0;
            rd_lost[i] = '0;
        end
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.func = 1'b0;
        in_ch.now_time = '0;
        in_ch.message_bytes = '0;
        in_ch.reader_slot = '0;
        in_ch.reader_active = 1'b0;
        in_ch.reader_position = '0;
        in_ch.reader_seen_time = '0;
        out_ch.ready = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_phases();
        drain();
        if (mismatches == 0) begin
            $display("** broadcast_ring_admission: PASSED **");
        end else begin
            $display("** broadcast_ring_admission: FAILED **");
        end
        $finish;
    end
endmodule

/* files.f */
+incdir+rtl
rtl/bra_pkg.sv
rtl/bra_ifs.sv
rtl/bra_ram.sv
rtl/bra_alu.sv
rtl/bra_regs.sv
rtl/bra_seq.sv
rtl/broadcast_ring_admission.sv
dv/tb_broadcast_ring_admission.sv
